[hw/rtl/cma_pkg.sv]
// cma_pkg: widths, angle constants, cordic control/status types and the
// arctangent table for the circular mean block
// depends on nothing
package cma_pkg;

  localparam int ANGLE_W = 18;   // input angle, signed 1/128 degree
  localparam int MEAN_W  = 16;   // result angle, unsigned 1/128 degree
  localparam int SUM_W   = 28;   // signed Q1.15 sums
  localparam int XY_W    = 48;   // cordic x and y
  localparam int Z_W     = 34;   // cordic angle, 2^-23 degree units
  localparam int IDX_W   = 5;    // step index into the arctangent table
  localparam int STEP_MAX = 24;

  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint SUM_MAX  = 134217727;

  localparam int MAX_SAMPLES_DEF  = 1024;
  localparam int CORDIC_STEPS_DEF = 16;

  typedef struct packed {
    logic load;   // start a new run of micro-rotations
    logic vec;    // 1: vectoring (drive y to zero), 0: rotation (drive z to zero)
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse after the last step
  } cordic_sts_t;

  // atan(2^-i) in units of 2^-23 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd377487360;
      5'd1:  v = 34'sd222843801;
      5'd2:  v = 34'sd117744544;
      5'd3:  v = 34'sd59768969;
      5'd4:  v = 34'sd30000467;
      5'd5:  v = 34'sd15014858;
      5'd6:  v = 34'sd7509261;
      5'd7:  v = 34'sd3754860;
      5'd8:  v = 34'sd1877459;
      5'd9:  v = 34'sd938733;
      5'd10: v = 34'sd469367;
      5'd11: v = 34'sd234683;
      5'd12: v = 34'sd117342;
      5'd13: v = 34'sd58671;
      5'd14: v = 34'sd29335;
      5'd15: v = 34'sd14668;
      5'd16: v = 34'sd7334;
      5'd17: v = 34'sd3667;
      5'd18: v = 34'sd1833;
      5'd19: v = 34'sd917;
      5'd20: v = 34'sd458;
      5'd21: v = 34'sd229;
      5'd22: v = 34'sd115;
      5'd23: v = 34'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/cma_if.sv]
// cma_in_if and cma_out_if: valid/ready channels of the circular mean block
// depends on cma_pkg
interface cma_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cma_pkg::ANGLE_W-1:0]     angle_sample;
  logic                                   last_sample;

  modport source (output valid, angle_sample, last_sample, input ready);
  modport sink   (input valid, angle_sample, last_sample, output ready);
endinterface

interface cma_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [cma_pkg::MEAN_W-1:0]             mean_angle;

  modport source (output valid, mean_angle, input ready);
  modport sink   (input valid, mean_angle, output ready);
endinterface

[hw/rtl/circular_mean_angle.sv]
// circular_mean_angle: top level, sequencer, range reduction, Q1.15 sums
// and result register around one shared cordic unit
// depends on cma_pkg, cma_if (cma_in_if, cma_out_if) and cma_cordic
//
// Circular mean of a run of phase angles in 1/128 degree units. Each sample
// is reduced modulo 360 degrees, turned into cosine and sine (Q1.15) by the
// cordic in rotation mode, and added into two saturating 28-bit sums. A
// sample with last_sample set then runs the same cordic in vectoring mode to
// get atan2 of the sums, rounds to 1/128 degree and wraps into 0..46079;
// the result goes out on out_chan and both sums are cleared (mean is 0 when
// both sums are zero). One sample is processed at a time and in_chan.ready
// is high only between samples. A sample is transferred, goes through range
// reduction and folding, then through the shared cordic unit; a last sample
// adds a setup step, a second run of the cordic and a load of the result
// register. The result register frees the output side: the next run
// starts while a result waits, and only a later result waits on out ready.
module circular_mean_angle #(
  parameter int MAX_SAMPLES  = cma_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = cma_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cma_in_if.sink     in_chan,
  cma_out_if.source  out_chan
);

  localparam int STEPS = (CORDIC_STEPS > cma_pkg::STEP_MAX) ? cma_pkg::STEP_MAX
                                                              : CORDIC_STEPS;
  localparam longint LIM_L = (longint'(MAX_SAMPLES) * 32767 > cma_pkg::SUM_MAX)
                             ? cma_pkg::SUM_MAX : longint'(MAX_SAMPLES) * 32767;
  localparam int AW = cma_pkg::ANGLE_W;
  localparam int SW = cma_pkg::SUM_W;
  localparam int XW = cma_pkg::XY_W;
  localparam int ZW = cma_pkg::Z_W;
  localparam int MW = cma_pkg::MEAN_W;

  localparam logic signed [SW:0]   LIM_POS = (SW+1)'(LIM_L);
  localparam logic signed [SW:0]   LIM_NEG = -(SW+1)'(LIM_L);
  localparam logic signed [XW-1:0] Q15_MAX = XW'(32767);
  localparam logic signed [XW-1:0] Q15_MIN = -XW'(32768);
  localparam logic signed [AW-1:0] A_FULL  = AW'(cma_pkg::FULL_TURN);
  localparam logic signed [AW-1:0] A_HALF  = AW'(cma_pkg::HALF_TURN);
  localparam logic signed [AW-1:0] A_Q1    = AW'(cma_pkg::QUARTER_TURN);
  localparam logic signed [AW-1:0] A_Q3    = AW'(3 * cma_pkg::QUARTER_TURN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROT,
    ST_VSETUP,
    ST_VEC,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic signed [AW-1:0]   a_r, a_nxt, af;
  logic                   last_r, last_nxt, flip_r, flip_nxt, fold_flip;
  logic signed [SW-1:0]   cos_sum_r, cos_sum_nxt, sin_sum_r, sin_sum_nxt;
  logic [MW-1:0]          res_r, res_nxt, out_mean_r, out_mean_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // cordic connections
  cma_pkg::cordic_ctl_t   cctl;
  cma_pkg::cordic_sts_t   csts;
  logic signed [XW-1:0]   cx0, cy0, cx, cy;
  logic signed [ZW-1:0]   cz0, cz;

  // post-rotation rounding and accumulation
  logic signed [XW-1:0]   xr, yr;
  logic signed [15:0]     cos_q, sin_q;
  logic signed [SW:0]     cs_add, ss_add, cs_sat, ss_sat;

  // vectoring setup and angle wrap
  logic signed [XW-1:0]   xs_sh, ys_sh;
  logic signed [ZW-1:0]   zr;
  logic signed [AW-1:0]   rr, rw;

  logic                   in_xfer;

  assign in_xfer = in_chan.valid && in_chan.ready;

  cma_cordic #(
    .STEPS (STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .x     (cx),
    .y     (cy),
    .z     (cz),
    .sts   (csts)
  );

  always_comb begin
    // fold into -90..90 degrees, remembering a half-turn flip
    af        = a_r;
    fold_flip = 1'b0;
    if (a_r > A_Q1 && a_r < A_Q3) begin
      af        = a_r - A_HALF;
      fold_flip = 1'b1;
    end else if (a_r >= A_Q3) begin
      af = a_r - A_FULL;
    end

    // round half up to Q1.15, undo the flip, saturate
    xr = (cx + XW'(16384)) >>> 15;
    yr = (cy + XW'(16384)) >>> 15;
    if (flip_r) begin
      xr = -xr;
      yr = -yr;
    end
    cos_q = (xr > Q15_MAX) ? 16'sh7fff : ((xr < Q15_MIN) ? 16'sh8000 : xr[15:0]);
    sin_q = (yr > Q15_MAX) ? 16'sh7fff : ((yr < Q15_MIN) ? 16'sh8000 : yr[15:0]);

    cs_add = (SW+1)'(cos_sum_r) + (SW+1)'(cos_q);
    ss_add = (SW+1)'(sin_sum_r) + (SW+1)'(sin_q);
    cs_sat = (cs_add > LIM_POS) ? LIM_POS : ((cs_add < LIM_NEG) ? LIM_NEG : cs_add);
    ss_sat = (ss_add > LIM_POS) ? LIM_POS : ((ss_add < LIM_NEG) ? LIM_NEG : ss_add);

    // sums scaled by 2^16 for the vectoring run
    xs_sh = XW'(cos_sum_r) <<< 16;
    ys_sh = XW'(sin_sum_r) <<< 16;

    // round half up to 1/128 degree, wrap once into 0..359.99 degrees
    zr = (cz + ZW'(32768)) >>> 16;
    rr = zr[AW-1:0];
    rw = rr;
    if (rr < 0) begin
      rw = rr + A_FULL;
    end else if (rr >= A_FULL) begin
      rw = rr - A_FULL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    last_nxt      = last_r;
    flip_nxt      = flip_r;
    cos_sum_nxt   = cos_sum_r;
    sin_sum_nxt   = sin_sum_r;
    res_nxt       = res_r;
    out_mean_nxt  = out_mean_r;
    out_valid_nxt = out_valid_r;
    cctl.load     = 1'b0;
    cctl.vec      = 1'b0;
    cx0           = XW'(cma_pkg::GAIN_Q30);
    cy0           = '0;
    cz0           = {af, 16'b0};

    // result taken downstream
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          a_nxt     = in_chan.angle_sample;
          last_nxt  = in_chan.last_sample;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // one full-turn correction per cycle, then start the rotation
        if (a_r < 0) begin
          a_nxt = a_r + A_FULL;
        end else if (a_r >= A_FULL) begin
          a_nxt = a_r - A_FULL;
        end else begin
          flip_nxt  = fold_flip;
          cctl.load = 1'b1;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (csts.done) begin
          cos_sum_nxt = cs_sat[SW-1:0];
          sin_sum_nxt = ss_sat[SW-1:0];
          state_nxt   = last_r ? ST_VSETUP : ST_IDLE;
        end
      end
      ST_VSETUP: begin
        if (cos_sum_r == '0 && sin_sum_r == '0) begin
          res_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          // left half plane: mirror through the origin and start at 180 degrees
          cctl.load = 1'b1;
          cctl.vec  = 1'b1;
          if (cos_sum_r < 0) begin
            cx0 = -xs_sh;
            cy0 = -ys_sh;
            cz0 = ZW'(cma_pkg::HALF_TURN * 65536);
          end else begin
            cx0 = xs_sh;
            cy0 = ys_sh;
            cz0 = '0;
          end
          state_nxt = ST_VEC;
        end
      end
      ST_VEC: begin
        if (csts.done) begin
          res_nxt   = rw[MW-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for a free result register, then close the run
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = res_r;
          cos_sum_nxt   = '0;
          sin_sum_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      flip_r      <= 1'b0;
      cos_sum_r   <= '0;
      sin_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      flip_r      <= flip_nxt;
      cos_sum_r   <= cos_sum_nxt;
      sin_sum_r   <= sin_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    res_r      <= res_nxt;
    out_mean_r <= out_mean_nxt;
  end

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.mean_angle = out_mean_r;

  // no sample taken while the shared unit is still iterating
  a_ready_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !csts.busy)
    else $error("input ready while cordic busy");

  // a sample transfer always starts a multi-cycle run
  a_xfer_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("input ready right after a transfer");

  // a new result only comes out of the emit step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

  // sums stay inside the saturation limit
  a_sum_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((SW+1)'(cos_sum_r) <= LIM_POS) && ((SW+1)'(cos_sum_r) >= LIM_NEG) &&
    ((SW+1)'(sin_sum_r) <= LIM_POS) && ((SW+1)'(sin_sum_r) >= LIM_NEG))
    else $error("sum beyond limit");

endmodule

[hw/rtl/cma_cordic.sv]
// cma_cordic: shared cordic micro-rotation unit with its own step counter,
// one step per cycle in rotation or vectoring mode
// depends on cma_pkg
module cma_cordic #(
  parameter int STEPS = cma_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cma_pkg::cordic_ctl_t               ctl,
  input  logic signed [cma_pkg::XY_W-1:0]    x0,
  input  logic signed [cma_pkg::XY_W-1:0]    y0,
  input  logic signed [cma_pkg::Z_W-1:0]     z0,
  output logic signed [cma_pkg::XY_W-1:0]    x,
  output logic signed [cma_pkg::XY_W-1:0]    y,
  output logic signed [cma_pkg::Z_W-1:0]     z,
  output cma_pkg::cordic_sts_t               sts
);

  localparam int CNT_W = $clog2(STEPS);

  logic signed [cma_pkg::XY_W-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [cma_pkg::Z_W-1:0]  z_r, z_nxt, da;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            run_r, run_nxt, done_r, done_nxt, vec_r, vec_nxt, ccw;

  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    da  = cma_pkg::atan_lut(cma_pkg::IDX_W'(cnt_r));
    // rotation turns toward z = 0, vectoring toward y = 0
    ccw = vec_r ? (y_r <= 0) : (z_r >= 0);

    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    vec_nxt  = vec_r;
    done_nxt = 1'b0;

    if (ctl.load) begin
      x_nxt   = x0;
      y_nxt   = y0;
      z_nxt   = z0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
      vec_nxt = ctl.vec;
    end else if (run_r) begin
      if (ccw) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - da;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + da;
      end
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      vec_r  <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      vec_r  <= vec_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x        = x_r;
  assign y        = y_r;
  assign z        = z_r;
  assign sts.busy = run_r;
  assign sts.done = done_r;

endmodule
